// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers that keep the concurrent checks in the RTL short.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is high.
`define AOFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aofc assertion failed");

// Next-cycle implication, gated off while reset is high.
`define AOFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aofc assertion failed");

`endif

// ===== hw/rtl/aofc_pkg.sv =====
// ----------------------------------------------------------------------------
// aofc_pkg
// Widths, codes, control word layout and microcode program of the filter chain.
// ----------------------------------------------------------------------------
package aofc_pkg;

   // Number formats: samples Q1.15, gain Q8.8, coefficients Q0.16, state Q8.16
   localparam int SAMPLE_W   = 16;
   localparam int STATE_W    = 24;
   localparam int COEFF_W    = 16;
   localparam int COEFF_FRAC = 16;
   localparam int GAIN_FRAC  = 8;
   localparam int STATE_FRAC = STATE_W - 8;
   localparam int GAIN_SHIFT = SAMPLE_W - 1 + GAIN_FRAC - STATE_FRAC;
   localparam int OUT_SHIFT  = STATE_FRAC - (SAMPLE_W - 1);

   // Multiplier operand holds a sum of three state values
   localparam int MOP_W  = STATE_W + 2;
   localparam int PROD_W = MOP_W + COEFF_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [COEFF_W-1:0] GAIN_RST = 16'd256;
   localparam logic [COEFF_W-1:0] HP1_RST  = 16'd65000;
   localparam logic [COEFF_W-1:0] HP2_RST  = 16'd62700;
   localparam logic [COEFF_W-1:0] LP_RST   = 16'd43000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN          = 3'd0,
      CSR_HP1_COEFF     = 3'd1,
      CSR_HP2_COEFF     = 3'd2,
      CSR_LP_COEFF      = 3'd3,
      CSR_OUTPUT_ENABLE = 3'd4
   } csr_index_type;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic [COEFF_W-1:0] gain;
      logic [COEFF_W-1:0] hp1_coeff;
      logic [COEFF_W-1:0] hp2_coeff;
      logic [COEFF_W-1:0] lp_coeff;
      logic               output_enable;
   } cfg_type;

   // Datapath flags seen by the jump logic
   typedef struct packed {
      logic restart;
      logic disabled;
      logic hp1_primed;
      logic hp2_primed;
   } status_type;

   // ---------------------------------------------------------------- control
   localparam int PC_W = 5;

   typedef enum logic [2:0] {
      MOP_NONE   = 3'd0,
      MOP_SAMPLE = 3'd1,
      MOP_HP1    = 3'd2,
      MOP_HP2    = 3'd3,
      MOP_LP     = 3'd4
   } mop_sel_type;

   typedef enum logic [1:0] {
      COEF_GAIN = 2'd0,
      COEF_HP1  = 2'd1,
      COEF_HP2  = 2'd2,
      COEF_LP   = 2'd3
   } coef_sel_type;

   typedef enum logic [2:0] {
      WB_NONE     = 3'd0,
      WB_GAIN     = 3'd1,
      WB_HP1      = 3'd2,
      WB_HP1_SEED = 3'd3,
      WB_HP2      = 3'd4,
      WB_HP2_SEED = 3'd5,
      WB_LP       = 3'd6,
      WB_CLEAR    = 3'd7
   } wb_sel_type;

   typedef enum logic [2:0] {
      JMP_NONE     = 3'd0,
      JMP_ALWAYS   = 3'd1,
      JMP_RESTART  = 3'd2,
      JMP_DISABLED = 3'd3,
      JMP_HP1_COLD = 3'd4,
      JMP_HP2_COLD = 3'd5
   } jmp_cond_type;

   typedef struct packed {
      mop_sel_type       mop_sel;
      logic              mul_en;
      coef_sel_type      coef_sel;
      wb_sel_type        wb_sel;
      jmp_cond_type      jmp_cond;
      logic [PC_W-1:0]   jmp_target;
      logic              emit;
      logic              finish;
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_NOP = '{
      mop_sel: MOP_NONE, mul_en: 1'b0, coef_sel: COEF_GAIN, wb_sel: WB_NONE,
      jmp_cond: JMP_NONE, jmp_target: '0, emit: 1'b0, finish: 1'b0
   };

   // Program steps
   localparam logic [PC_W-1:0] STEP_FETCH    = 5'd0;
   localparam logic [PC_W-1:0] STEP_GAIN_MUL = 5'd1;
   localparam logic [PC_W-1:0] STEP_GAIN_WB  = 5'd2;
   localparam logic [PC_W-1:0] STEP_HP1_OP   = 5'd3;
   localparam logic [PC_W-1:0] STEP_HP1_MUL  = 5'd4;
   localparam logic [PC_W-1:0] STEP_HP1_WB   = 5'd5;
   localparam logic [PC_W-1:0] STEP_HP1_SEED = 5'd6;
   localparam logic [PC_W-1:0] STEP_HP2_OP   = 5'd7;
   localparam logic [PC_W-1:0] STEP_HP2_MUL  = 5'd8;
   localparam logic [PC_W-1:0] STEP_HP2_WB   = 5'd9;
   localparam logic [PC_W-1:0] STEP_HP2_SEED = 5'd10;
   localparam logic [PC_W-1:0] STEP_LP_OP    = 5'd11;
   localparam logic [PC_W-1:0] STEP_LP_MUL   = 5'd12;
   localparam logic [PC_W-1:0] STEP_LP_WB    = 5'd13;
   localparam logic [PC_W-1:0] STEP_EMIT     = 5'd14;
   localparam logic [PC_W-1:0] STEP_RESTART  = 5'd15;
   localparam logic [PC_W-1:0] STEP_DROP     = 5'd16;

   // Microcode ROM
   function automatic ctrl_word_type ucode_word(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = CTRL_NOP;
      unique case (pc)
         STEP_FETCH: begin
            w.mop_sel    = MOP_SAMPLE;
            w.jmp_cond   = JMP_RESTART;
            w.jmp_target = STEP_RESTART;
         end
         STEP_GAIN_MUL: begin
            w.mul_en     = 1'b1;
            w.coef_sel   = COEF_GAIN;
            w.jmp_cond   = JMP_DISABLED;
            w.jmp_target = STEP_DROP;
         end
         STEP_GAIN_WB: begin
            w.wb_sel     = WB_GAIN;
            w.jmp_cond   = JMP_HP1_COLD;
            w.jmp_target = STEP_HP1_SEED;
         end
         STEP_HP1_OP: w.mop_sel = MOP_HP1;
         STEP_HP1_MUL: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_HP1;
         end
         STEP_HP1_WB: begin
            w.wb_sel     = WB_HP1;
            w.jmp_cond   = JMP_ALWAYS;
            w.jmp_target = STEP_HP2_OP;
         end
         STEP_HP1_SEED: w.wb_sel = WB_HP1_SEED;
         STEP_HP2_OP: begin
            w.mop_sel    = MOP_HP2;
            w.jmp_cond   = JMP_HP2_COLD;
            w.jmp_target = STEP_HP2_SEED;
         end
         STEP_HP2_MUL: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_HP2;
         end
         STEP_HP2_WB: begin
            w.wb_sel     = WB_HP2;
            w.jmp_cond   = JMP_ALWAYS;
            w.jmp_target = STEP_LP_OP;
         end
         STEP_HP2_SEED: w.wb_sel = WB_HP2_SEED;
         STEP_LP_OP: w.mop_sel = MOP_LP;
         STEP_LP_MUL: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_LP;
         end
         STEP_LP_WB: w.wb_sel = WB_LP;
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.finish = 1'b1;
         end
         STEP_RESTART: begin
            w.wb_sel = WB_CLEAR;
            w.finish = 1'b1;
         end
         default: w.finish = 1'b1;
      endcase
      return w;
   endfunction

   // Clamp a wide signed value to the state range
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [PROD_W-1:0] v
   );
      logic [PROD_W-STATE_W:0] upper;
      upper = v[PROD_W-1:STATE_W-1];
      if ((&upper) || !(|upper)) begin
         return v[STATE_W-1:0];
      end else if (v[PROD_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

endpackage

// ===== hw/rtl/aofc_sequencer.sv =====
// ----------------------------------------------------------------------------
// aofc_sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module aofc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   stall,
   input  aofc_pkg::status_type   status,
   output aofc_pkg::ctrl_word_type ctrl,
   output logic                   busy
);

   logic                      busy_ff, busy_in;
   logic [aofc_pkg::PC_W-1:0] pc_ff, pc_in;
   aofc_pkg::ctrl_word_type   word;
   logic                      taken;

   always_comb begin
      word = aofc_pkg::ucode_word(pc_ff);
   end

   always_comb begin
      unique case (word.jmp_cond)
         aofc_pkg::JMP_ALWAYS:   taken = 1'b1;
         aofc_pkg::JMP_RESTART:  taken = status.restart;
         aofc_pkg::JMP_DISABLED: taken = status.disabled;
         aofc_pkg::JMP_HP1_COLD: taken = !status.hp1_primed;
         aofc_pkg::JMP_HP2_COLD: taken = !status.hp2_primed;
         default:                taken = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = aofc_pkg::STEP_FETCH;
      end else if (busy_ff && !stall) begin
         if (word.finish) begin
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = word.jmp_target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= aofc_pkg::STEP_FETCH;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   // Idle steps drive nothing into the datapath
   assign ctrl = busy_ff ? word : aofc_pkg::CTRL_NOP;
   assign busy = busy_ff;

endmodule

// ===== hw/rtl/aofc_datapath.sv =====
// ----------------------------------------------------------------------------
// aofc_datapath
// Filter state, operand register and the one shared multiplier.
// ----------------------------------------------------------------------------
module aofc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_load,
   input  logic                                item_opcode,
   input  logic signed [aofc_pkg::SAMPLE_W-1:0] item_sample,
   input  aofc_pkg::cfg_type                   cfg,
   input  aofc_pkg::ctrl_word_type             ctrl,
   output aofc_pkg::status_type                status,
   output logic signed [aofc_pkg::SAMPLE_W-1:0] emit_sample,
   output logic                                emit_clip
);

   localparam int SW = aofc_pkg::STATE_W;
   localparam int MW = aofc_pkg::MOP_W;
   localparam int PW = aofc_pkg::PROD_W;

   // Latched item
   logic                                 restart_ff;
   logic signed [aofc_pkg::SAMPLE_W-1:0] sample_ff;

   // Working registers
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [MW-1:0] mop_ff, mop_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   // Filter state
   logic                 hp1_primed_ff, hp1_primed_in;
   logic signed [SW-1:0] hp1_last_in_ff, hp1_last_in_in;
   logic signed [SW-1:0] hp1_last_out_ff, hp1_last_out_in;
   logic                 hp2_primed_ff, hp2_primed_in;
   logic signed [SW-1:0] hp2_last_in_ff, hp2_last_in_in;
   logic signed [SW-1:0] hp2_last_out_ff, hp2_last_out_in;
   logic signed [SW-1:0] lp_last_out_ff, lp_last_out_in;

   logic signed [aofc_pkg::COEFF_W:0] coef_ext;
   logic signed [SW-1:0]              gain_res, coef_res, lp_res;
   logic signed [PW-1:0]              prod_shr;
   logic signed [SW-1:0]              out_shr;
   logic [SW-aofc_pkg::SAMPLE_W:0]    out_upper;

   // Operand for the next multiply
   always_comb begin
      unique case (ctrl.mop_sel)
         aofc_pkg::MOP_SAMPLE: mop_in = MW'(sample_ff);
         aofc_pkg::MOP_HP1:    mop_in = MW'(hp1_last_out_ff) + MW'(x_ff) - MW'(hp1_last_in_ff);
         aofc_pkg::MOP_HP2:    mop_in = MW'(hp2_last_out_ff) + MW'(x_ff) - MW'(hp2_last_in_ff);
         aofc_pkg::MOP_LP:     mop_in = MW'(x_ff) - MW'(lp_last_out_ff);
         default:              mop_in = mop_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.coef_sel)
         aofc_pkg::COEF_GAIN: coef_ext = $signed({1'b0, cfg.gain});
         aofc_pkg::COEF_HP1:  coef_ext = $signed({1'b0, cfg.hp1_coeff});
         aofc_pkg::COEF_HP2:  coef_ext = $signed({1'b0, cfg.hp2_coeff});
         default:             coef_ext = $signed({1'b0, cfg.lp_coeff});
      endcase
      prod_in = ctrl.mul_en ? (mop_ff * coef_ext) : prod_ff;
   end

   // Floor shifts and clamps of the registered product
   always_comb begin
      prod_shr = prod_ff >>> aofc_pkg::COEFF_FRAC;
      gain_res = aofc_pkg::sat_state(prod_ff >>> aofc_pkg::GAIN_SHIFT);
      coef_res = aofc_pkg::sat_state(prod_shr);
      lp_res   = aofc_pkg::sat_state(PW'(lp_last_out_ff) + prod_shr);
   end

   always_comb begin
      x_in            = x_ff;
      hp1_primed_in   = hp1_primed_ff;
      hp1_last_in_in  = hp1_last_in_ff;
      hp1_last_out_in = hp1_last_out_ff;
      hp2_primed_in   = hp2_primed_ff;
      hp2_last_in_in  = hp2_last_in_ff;
      hp2_last_out_in = hp2_last_out_ff;
      lp_last_out_in  = lp_last_out_ff;
      unique case (ctrl.wb_sel)
         aofc_pkg::WB_GAIN: x_in = gain_res;
         aofc_pkg::WB_HP1: begin
            hp1_last_out_in = coef_res;
            hp1_last_in_in  = x_ff;
            x_in            = coef_res;
         end
         aofc_pkg::WB_HP1_SEED: begin
            hp1_last_out_in = x_ff;
            hp1_last_in_in  = x_ff;
            hp1_primed_in   = 1'b1;
         end
         aofc_pkg::WB_HP2: begin
            hp2_last_out_in = coef_res;
            hp2_last_in_in  = x_ff;
            x_in            = coef_res;
         end
         aofc_pkg::WB_HP2_SEED: begin
            hp2_last_out_in = x_ff;
            hp2_last_in_in  = x_ff;
            hp2_primed_in   = 1'b1;
         end
         aofc_pkg::WB_LP: lp_last_out_in = lp_res;
         aofc_pkg::WB_CLEAR: begin
            hp1_primed_in   = 1'b0;
            hp1_last_in_in  = '0;
            hp1_last_out_in = '0;
            hp2_primed_in   = 1'b0;
            hp2_last_in_in  = '0;
            hp2_last_out_in = '0;
            lp_last_out_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         restart_ff <= (item_opcode == aofc_pkg::OP_RESTART);
         sample_ff  <= item_sample;
      end
      x_ff    <= x_in;
      mop_ff  <= mop_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hp1_primed_ff   <= 1'b0;
         hp1_last_in_ff  <= '0;
         hp1_last_out_ff <= '0;
         hp2_primed_ff   <= 1'b0;
         hp2_last_in_ff  <= '0;
         hp2_last_out_ff <= '0;
         lp_last_out_ff  <= '0;
      end else begin
         hp1_primed_ff   <= hp1_primed_in;
         hp1_last_in_ff  <= hp1_last_in_in;
         hp1_last_out_ff <= hp1_last_out_in;
         hp2_primed_ff   <= hp2_primed_in;
         hp2_last_in_ff  <= hp2_last_in_in;
         hp2_last_out_ff <= hp2_last_out_in;
         lp_last_out_ff  <= lp_last_out_in;
      end
   end

   // Bring the low-pass state back to sample format and clamp
   always_comb begin
      out_shr   = lp_last_out_ff >>> aofc_pkg::OUT_SHIFT;
      out_upper = out_shr[SW-1:aofc_pkg::SAMPLE_W-1];
      if ((&out_upper) || !(|out_upper)) begin
         emit_sample = out_shr[aofc_pkg::SAMPLE_W-1:0];
         emit_clip   = 1'b0;
      end else if (out_shr[SW-1]) begin
         emit_sample = {1'b1, {(aofc_pkg::SAMPLE_W-1){1'b0}}};
         emit_clip   = 1'b1;
      end else begin
         emit_sample = {1'b0, {(aofc_pkg::SAMPLE_W-1){1'b1}}};
         emit_clip   = 1'b1;
      end
   end

   assign status.restart    = restart_ff;
   assign status.disabled   = !cfg.output_enable;
   assign status.hp1_primed = hp1_primed_ff;
   assign status.hp2_primed = hp2_primed_ff;

endmodule

// ===== hw/rtl/audio_output_filter_chain_top.sv =====
// ----------------------------------------------------------------------------
// audio_output_filter_chain_top
// Gain, two RC high-pass stages and one RC low-pass stage for mixer samples.
// ----------------------------------------------------------------------------
// Usage: each sample item (opcode 0) is scaled by the Q8.8 gain, runs through
// two first-order high-pass stages and one first-order low-pass stage, and
// leaves as one saturated Q1.15 item with a clip flag. A restart item
// (opcode 1) clears all filter state and gives no result; while output_enable
// is 0, sample items are consumed and give nothing. The first sample after a
// restart seeds each high-pass stage and passes through it unchanged. Items
// are taken one at a time: the next item is accepted only once the microcode
// program of the previous one has finished, and a seeding sample, a restart
// and a sample while disabled run shorter programs than a sample on a primed
// chain. The microcode program runs the four dependent multiplies one after the
// other through a single shared 26x17 multiplier, with the operand and the
// product each registered. A finished item waits in the output register, so
// the next item is taken while the previous one is still unread; the program
// only holds at its emit step if that register is still full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_output_filter_chain_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // input item channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [aofc_pkg::SAMPLE_W-1:0]   req_sample_in,
   // result item channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [aofc_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                                   rsp_clipped,
   // configuration writes
   input  logic                                   csr_we,
   input  logic [aofc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [aofc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   aofc_pkg::cfg_type        cfg_ff, cfg_in;
   aofc_pkg::ctrl_word_type  ctrl;
   aofc_pkg::status_type     status;
   logic                     seq_busy;
   logic                     accept;
   logic                     hold;
   logic                     emit_fire;

   logic signed [aofc_pkg::SAMPLE_W-1:0] emit_sample;
   logic                                 emit_clip;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [aofc_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                                 rsp_clipped_ff;

   // Configuration registers; writes to unknown indexes drop silently
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            aofc_pkg::CSR_GAIN:          cfg_in.gain          = csr_wdata;
            aofc_pkg::CSR_HP1_COEFF:     cfg_in.hp1_coeff     = csr_wdata;
            aofc_pkg::CSR_HP2_COEFF:     cfg_in.hp2_coeff     = csr_wdata;
            aofc_pkg::CSR_LP_COEFF:      cfg_in.lp_coeff      = csr_wdata;
            aofc_pkg::CSR_OUTPUT_ENABLE: cfg_in.output_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain          <= aofc_pkg::GAIN_RST;
         cfg_ff.hp1_coeff     <= aofc_pkg::HP1_RST;
         cfg_ff.hp2_coeff     <= aofc_pkg::HP2_RST;
         cfg_ff.lp_coeff      <= aofc_pkg::LP_RST;
         cfg_ff.output_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a new item whenever the program is not running
   assign req_ready = !seq_busy;
   assign accept    = req_valid && req_ready;

   // Hold the emit step while the output register still holds an unread item
   assign hold      = ctrl.emit && rsp_valid_ff && !rsp_ready;
   assign emit_fire = ctrl.emit && !hold;

   aofc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .stall  (hold),
      .status (status),
      .ctrl   (ctrl),
      .busy   (seq_busy)
   );

   aofc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .item_load   (accept),
      .item_opcode (req_opcode),
      .item_sample (req_sample_in),
      .cfg         (cfg_ff),
      .ctrl        (ctrl),
      .status      (status),
      .emit_sample (emit_sample),
      .emit_clip   (emit_clip)
   );

   // Output register: advance on emit, drop valid once the item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_sample_ff  <= emit_sample;
         rsp_clipped_ff <= emit_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   // An accepted item always starts the program
   `AOFC_ASSERT_NEXT(a_accept_starts, clock, reset, accept, seq_busy)
   // A result only appears right after a running program emitted it
   `AOFC_ASSERT_IMPLY(a_rsp_from_program, clock, reset, $rose(rsp_valid_ff), $past(seq_busy))
   // The second high-pass stage is never primed ahead of the first
   `AOFC_ASSERT_IMPLY(a_prime_order, clock, reset, status.hp2_primed, status.hp1_primed)

endmodule

// ===== verif/tb_audio_output_filter_chain_top.sv =====
// ----------------------------------------------------------------------------
// tb_audio_output_filter_chain_top
// Self-checking bench for the gain, high-pass, high-pass, low-pass sample chain.
// ----------------------------------------------------------------------------
// Items go in on the request channel with random gaps. A predictor with its
// own copy of the register values and the filter state works out each
// filtered sample when its item is accepted. A checker compares every result
// item, in order, against the oldest prediction. Directed tests cover reset
// register values, disabled output, restart and the extreme register values.
// A back-pressure test holds the result channel off for a long stretch.
// Random phases with changing register values follow.
// ----------------------------------------------------------------------------
module tb_audio_output_filter_chain_top;
   import aofc_pkg::*;

   // Settle time after the last result before a register write or the end;
   // covers the longest item program with margin.
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       clipped;
   } filtered_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_opcode;
   logic signed [SAMPLE_W-1:0]   req_sample_in;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic                         rsp_clipped;
   logic                         csr_we;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;

   // Predictor: register values and filter state
   cfg_type      chain_cfg;
   bit           hpa_seeded;
   longint       hpa_in_z;
   longint       hpa_out_z;
   bit           hpb_seeded;
   longint       hpb_in_z;
   longint       hpb_out_z;
   longint       lpf_out_z;

   // Filtered samples still owed by the block, oldest first
   filtered_type pending_samples[$];
   filtered_type head_item;
   int           errors;

   // Idling control for the sender and the receiver
   bit           quiet;
   int           hold_request;
   int           hold_left;
   int           stall_left;

   audio_output_filter_chain_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------- predictor

   // Clamp to a signed range of the given width and flag when it bites.
   function automatic longint saturate_to(input longint v, input int w, output bit hit);
      longint hi;
      longint lo;
      hi  = (longint'(1) <<< (w - 1)) - 1;
      lo  = -hi - 1;
      hit = 1'b0;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // One RC high-pass step; the first sample after a restart seeds the stage.
   function automatic longint high_pass_step(input longint x, input logic [COEFF_W-1:0] a,
                                             inout bit seeded, inout longint in_z,
                                             inout longint out_z);
      bit hit;
      if (seeded) begin
         out_z = saturate_to(((out_z + x - in_z) * longint'(a)) >>> COEFF_FRAC,
                             STATE_W, hit);
      end else begin
         out_z  = x;
         seeded = 1'b1;
      end
      in_z = x;
      return out_z;
   endfunction

   function automatic void clear_filters();
      hpa_seeded = 1'b0;
      hpa_in_z   = 0;
      hpa_out_z  = 0;
      hpb_seeded = 1'b0;
      hpb_in_z   = 0;
      hpb_out_z  = 0;
      lpf_out_z  = 0;
   endfunction

   // Advance the predictor by one accepted item and queue what it yields.
   function automatic void predict_filtered(input logic op,
                                            input logic signed [SAMPLE_W-1:0] pcm);
      longint       x;
      longint       y;
      bit           hit;
      filtered_type res;
      if (op == OP_RESTART) begin
         clear_filters();
         return;
      end
      // Disabled: sample is consumed, state untouched
      if (!chain_cfg.output_enable) return;
      x = saturate_to((longint'(pcm) * longint'(chain_cfg.gain)) >>> GAIN_SHIFT,
                      STATE_W, hit);
      x = high_pass_step(x, chain_cfg.hp1_coeff, hpa_seeded, hpa_in_z, hpa_out_z);
      x = high_pass_step(x, chain_cfg.hp2_coeff, hpb_seeded, hpb_in_z, hpb_out_z);
      y = lpf_out_z + (((x - lpf_out_z) * longint'(chain_cfg.lp_coeff)) >>> COEFF_FRAC);
      lpf_out_z = saturate_to(y, STATE_W, hit);
      // Only the final narrowing to sample width reports clipping
      y = saturate_to(lpf_out_z >>> OUT_SHIFT, SAMPLE_W, hit);
      res.pcm     = y[SAMPLE_W-1:0];
      res.clipped = hit;
      pending_samples.push_back(res);
   endfunction

   // ------------------------------------------------------------- idling

   // Mostly short pauses, now and then a long one.
   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stalls, plus the long hold-off a test may request.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (!quiet && $urandom_range(0, 99) < 25) stall_left = pick_pause();
      end
   end

   // ------------------------------------------------------------- checker

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected output item: sample_out %0d clipped %0b",
                        rsp_sample_out, rsp_clipped);
         end else begin
            head_item = pending_samples.pop_front();
            if (rsp_sample_out !== head_item.pcm || rsp_clipped !== head_item.clipped) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("output mismatch: expected sample_out %0d clipped %0b, got %0d %0b",
                           head_item.pcm, head_item.clipped, rsp_sample_out, rsp_clipped);
            end
         end
      end
   end

   // ------------------------------------------------------------- drivers

   // Offer one item after an optional gap and hold it until accepted.
   // Valid stays high on return so a following item can go back to back.
   task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] pcm);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 35) ? pick_pause() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_opcode    = op;
      req_sample_in = pcm;
      do @(posedge clock); while (!req_ready);
      predict_filtered(op, pcm);
   endtask

   // Drop valid, wait for every owed result, then let the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; unknown indexes leave the register values alone.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_GAIN:          chain_cfg.gain          = data;
         CSR_HP1_COEFF:     chain_cfg.hp1_coeff     = data;
         CSR_HP2_COEFF:     chain_cfg.hp2_coeff     = data;
         CSR_LP_COEFF:      chain_cfg.lp_coeff      = data;
         CSR_OUTPUT_ENABLE: chain_cfg.output_enable = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [COEFF_W-1:0] g, input logic [COEFF_W-1:0] h1,
                            input logic [COEFF_W-1:0] h2, input logic [COEFF_W-1:0] lp);
      write_reg(CSR_GAIN, g);
      write_reg(CSR_HP1_COEFF, h1);
      write_reg(CSR_HP2_COEFF, h2);
      write_reg(CSR_LP_COEFF, lp);
   endtask

   // ------------------------------------------------------------- tests

   // Output starts disabled: samples and a restart give nothing.
   task automatic test_disabled_after_reset();
      send_item(OP_SAMPLE, 16'sh7FFF);
      send_item(OP_RESTART, 16'sh0000);
      send_item(OP_SAMPLE, -16'sh8000);
      send_item(OP_SAMPLE, 16'sh1234);
      wait_idle();
   endtask

   // Enable output and run extremes through the reset gain and coefficients.
   task automatic test_reset_settings();
      write_reg(CSR_OUTPUT_ENABLE, 16'h0001);
      send_item(OP_SAMPLE, 16'sh7FFF);
      send_item(OP_SAMPLE, -16'sh8000);
      send_item(OP_SAMPLE, 16'sh0000);
      send_item(OP_SAMPLE, -16'sh0001);
      send_item(OP_SAMPLE, 16'sh0001);
      send_item(OP_SAMPLE, 16'sh3039);
      wait_idle();
   endtask

   // Full-scale gain and coefficients saturate the chain; then all zero.
   // Writes to unused indexes must change nothing.
   task automatic test_extreme_settings();
      int idx;
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (idx = CSR_OUTPUT_ENABLE + 1; idx < (1 << CSR_IDX_W); idx++)
         write_reg(idx[CSR_IDX_W-1:0], 16'h0000);
      send_item(OP_RESTART, 16'sh7FFF);
      send_item(OP_SAMPLE, 16'sh7FFF);
      send_item(OP_SAMPLE, -16'sh8000);
      send_item(OP_SAMPLE, 16'sh7FFF);
      send_item(OP_SAMPLE, -16'sh8000);
      wait_idle();
      write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_RESTART, -16'sh8000);
      send_item(OP_SAMPLE, 16'sh7FFF);
      send_item(OP_SAMPLE, -16'sh8000);
      wait_idle();
   endtask

   // Disable between primed samples: state must carry over unchanged.
   task automatic test_disable_midstream();
      write_all(GAIN_RST, HP1_RST, HP2_RST, LP_RST);
      send_item(OP_SAMPLE, 16'sh4000);
      wait_idle();
      write_reg(CSR_OUTPUT_ENABLE, 16'h0000);
      send_item(OP_SAMPLE, -16'sh4000);
      send_item(OP_SAMPLE, 16'sh7FFF);
      wait_idle();
      write_reg(CSR_OUTPUT_ENABLE, 16'hFFFF);
      send_item(OP_SAMPLE, -16'sh2000);
      send_item(OP_SAMPLE, 16'sh2000);
      wait_idle();
   endtask

   // Hold the result side off while items keep coming, so the output
   // register fills, the program parks at its emit step and input stalls.
   task automatic test_output_backpressure();
      int n;
      quiet        = 1'b1;
      hold_request = 300;
      for (n = 0; n < 12; n++)
         send_item(OP_SAMPLE, SAMPLE_W'($urandom_range(0, 65535)));
      quiet = 1'b0;
      wait_idle();
   endtask

   function automatic logic [COEFF_W-1:0] pick_coeff();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return COEFF_W'($urandom_range(40000, 65535));
         default: return COEFF_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [COEFF_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return COEFF_W'($urandom_range(64, 1024));
         default: return COEFF_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Random phases: fresh register values, then a stream of samples with the
   // odd restart. One phase runs with output disabled.
   task automatic test_random_streams();
      int phase;
      int n;
      int count;
      int r;
      logic signed [SAMPLE_W-1:0] pcm;
      pcm = '0;
      for (phase = 0; phase < 14; phase++) begin
         wait_idle();
         write_all(pick_gain(), pick_coeff(), pick_coeff(), pick_coeff());
         write_reg(CSR_IDX_W'($urandom_range(CSR_OUTPUT_ENABLE + 1, (1 << CSR_IDX_W) - 1)),
                   CSR_DATA_W'($urandom_range(0, 65535)));
         write_reg(CSR_OUTPUT_ENABLE, (phase == 5) ? 16'h0000 : 16'h0001);
         quiet = (phase % 4 == 3);
         count = (phase == 5) ? 40 : 100;
         for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            // Hold the last value now and then so the filters settle
            if (r < 8) ;
            else if (r < 18) begin
               case ($urandom_range(0, 3))
                  0:       pcm = 16'sh7FFF;
                  1:       pcm = -16'sh8000;
                  2:       pcm = 16'sh0000;
                  default: pcm = -16'sh0001;
               endcase
            end else if (r < 35) pcm = SAMPLE_W'($urandom_range(0, 511) - 256);
            else pcm = SAMPLE_W'($urandom_range(0, 65535));
            send_item(($urandom_range(0, 99) < 3) ? OP_RESTART : OP_SAMPLE, pcm);
         end
         quiet = 1'b0;
      end
      wait_idle();
   endtask

   // ------------------------------------------------------------- sequence

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_SAMPLE;
      req_sample_in = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_GAIN;
      csr_wdata     = '0;
      errors        = 0;
      quiet         = 1'b0;
      hold_request  = 0;
      hold_left     = 0;
      stall_left    = 0;
      chain_cfg     = '{gain: GAIN_RST, hp1_coeff: HP1_RST, hp2_coeff: HP2_RST,
                        lp_coeff: LP_RST, output_enable: 1'b0};
      clear_filters();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_after_reset();
      test_reset_settings();
      test_extreme_settings();
      test_disable_midstream();
      test_output_backpressure();
      test_random_streams();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
